### hdl/dmsh_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package dmsh_pkg;

    localparam int WORD_W  = 32;
    localparam int STEP_W  = 5;

    // configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_MD5_FIRST  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MD5_SECOND = 1'd1;

    // microinstruction kinds
    localparam logic [1:0] OP_MUL  = 2'd0;
    localparam logic [1:0] OP_WAIT = 2'd1;
    localparam logic [1:0] OP_MID  = 2'd2;
    localparam logic [1:0] OP_END  = 2'd3;

    // multiplier x operand
    localparam logic [2:0] X_RA      = 3'd0;
    localparam logic [2:0] X_SWAP_RA = 3'd1;
    localparam logic [2:0] X_RB      = 3'd2;
    localparam logic [2:0] X_SWAP_RB = 3'd3;
    localparam logic [2:0] X_RB_HI   = 3'd4;

    // multiplier y operand
    localparam logic Y_KEY   = 1'b0;
    localparam logic Y_TABLE = 1'b1;

    // constant tables
    localparam logic TAB_A = 1'b0;
    localparam logic TAB_B = 1'b1;

    // destination of the product
    localparam logic [1:0] D_RA = 2'd0;
    localparam logic [1:0] D_RB = 2'd1;
    localparam logic [1:0] D_RT = 2'd2;

    // addend to the product
    localparam logic [1:0] ADD_NONE = 2'd0;
    localparam logic [1:0] ADD_RT   = 2'd1;
    localparam logic [1:0] ADD_RB   = 2'd2;

    // program addresses
    localparam logic [STEP_W-1:0] STEP_WAIT = 5'd0;
    localparam logic [STEP_W-1:0] STEP_MID  = 5'd11;
    localparam logic [STEP_W-1:0] STEP_END  = 5'd22;

    typedef struct packed {
        logic [1:0]        op;
        logic              row;
        logic [2:0]        xsel;
        logic              ysel;
        logic              tab;
        logic [1:0]        kidx;
        logic [1:0]        dst;
        logic [1:0]        addsel;
        logic              jump;
        logic [STEP_W-1:0] target;
    } cw_t;

    typedef struct packed {
        cw_t  cw;
        logic adv;
    } ctrl_t;

    typedef struct packed {
        logic last;
        logic out_busy;
    } status_t;

    function automatic logic [WORD_W-1:0] scr_const(input logic tab, input logic row,
                                                    input logic [1:0] k);
        logic [WORD_W-1:0] c;
        case ({tab, row, k})
            4'b0000: c = 32'hCF98B111;
            4'b0001: c = 32'h87085B9F;
            4'b0010: c = 32'h12CEB96D;
            4'b0011: c = 32'h257E1D83;
            4'b0100: c = 32'hA27416F5;
            4'b0101: c = 32'hD38396FF;
            4'b0110: c = 32'h7C932B89;
            4'b0111: c = 32'hBFA49F69;
            4'b1000: c = 32'hEF0569FB;
            4'b1001: c = 32'h689B6B9F;
            4'b1010: c = 32'h79F8A395;
            4'b1011: c = 32'hC3EFEA97;
            4'b1100: c = 32'hC31713DB;
            4'b1101: c = 32'hDDCD1F0F;
            4'b1110: c = 32'h59C3AF2D;
            4'b1111: c = 32'h35BD1EC9;
            default: c = '0;
        endcase
        return c;
    endfunction

    // Program: wait/load, ten multiplies for the even word, commit/load,
    // ten multiplies for the odd word, commit/emit and jump back.
    function automatic cw_t ucode(input logic [STEP_W-1:0] step);
        cw_t               cw;
        logic [STEP_W-1:0] slot;
        cw        = '0;
        cw.op     = OP_MUL;
        cw.xsel   = X_RA;
        cw.ysel   = Y_KEY;
        cw.tab    = TAB_A;
        cw.dst    = D_RT;
        cw.addsel = ADD_NONE;
        cw.target = STEP_WAIT;
        slot      = '0;
        if (step == STEP_WAIT) begin
            cw.op = OP_WAIT;
        end else if (step == STEP_MID) begin
            cw.op  = OP_MID;
            cw.row = 1'b1;
        end else if (step == STEP_END) begin
            cw.op   = OP_END;
            cw.row  = 1'b1;
            cw.jump = 1'b1;
        end else begin
            if (step > STEP_MID) begin
                cw.row = 1'b1;
                slot   = step - STEP_MID - 5'd1;
            end else begin
                slot   = step - STEP_WAIT - 5'd1;
            end
            case (slot)
                5'd0: begin
                    cw.xsel = X_RA;      cw.ysel = Y_KEY;   cw.dst = D_RA;
                end
                5'd1: begin
                    cw.xsel = X_SWAP_RA; cw.ysel = Y_TABLE; cw.tab = TAB_A;
                    cw.kidx = 2'd0;      cw.dst  = D_RA;
                end
                5'd2: begin
                    cw.xsel = X_SWAP_RA; cw.ysel = Y_TABLE; cw.tab = TAB_A;
                    cw.kidx = 2'd1;      cw.dst  = D_RA;
                end
                5'd3: begin
                    cw.xsel = X_SWAP_RA; cw.ysel = Y_TABLE; cw.tab = TAB_A;
                    cw.kidx = 2'd2;      cw.dst  = D_RA;
                end
                5'd4: begin
                    cw.xsel = X_SWAP_RA; cw.ysel = Y_TABLE; cw.tab = TAB_A;
                    cw.kidx = 2'd3;      cw.dst  = D_RA;
                end
                5'd5: begin
                    cw.xsel = X_SWAP_RB; cw.ysel = Y_TABLE; cw.tab = TAB_B;
                    cw.kidx = 2'd0;      cw.dst  = D_RT;
                end
                5'd6: begin
                    cw.xsel = X_RB;      cw.ysel = Y_KEY;
                    cw.dst  = D_RB;      cw.addsel = ADD_RT;
                end
                5'd7: begin
                    cw.xsel = X_RB_HI;   cw.ysel = Y_TABLE; cw.tab = TAB_B;
                    cw.kidx = 2'd1;      cw.dst  = D_RT;
                end
                5'd8: begin
                    cw.xsel = X_RB;      cw.ysel = Y_TABLE; cw.tab = TAB_B;
                    cw.kidx = 2'd2;      cw.dst  = D_RB;    cw.addsel = ADD_RT;
                end
                5'd9: begin
                    cw.xsel = X_SWAP_RB; cw.ysel = Y_TABLE; cw.tab = TAB_B;
                    cw.kidx = 2'd3;      cw.dst  = D_RB;    cw.addsel = ADD_RB;
                end
                default: begin
                    // unused addresses: harmless scratch write, return to wait
                    cw.jump = 1'b1;
                end
            endcase
        end
        return cw;
    endfunction

endpackage
`default_nettype wire

### hdl/dmsh_seq.sv
`timescale 1ns / 1ps
`default_nettype none
module dmsh_seq (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            s_tvalid,
    output logic                 s_tready,
    input  wire dmsh_pkg::status_t status,
    output dmsh_pkg::ctrl_t      ctrl
);
    import dmsh_pkg::*;

    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;
    cw_t               cw;
    logic              adv;

    assign cw = ucode(step_reg);

    // hold on the wait step without a request, and on the final step of a last block
    // while an earlier result is still not taken
    always_comb begin
        case (cw.op)
            OP_WAIT: adv = s_tvalid;
            OP_END:  adv = !(status.last && status.out_busy);
            default: adv = 1'b1;
        endcase
    end

    always_comb begin
        step_next = step_reg;
        if (adv) begin
            step_next = cw.jump ? cw.target : step_reg + 5'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= STEP_WAIT;
        end else begin
            step_reg <= step_next;
        end
    end

    assign s_tready = (cw.op == OP_WAIT);
    assign ctrl.cw  = cw;
    assign ctrl.adv = adv;

endmodule
`default_nettype wire

### hdl/dmsh_dp.sv
`timescale 1ns / 1ps
`default_nettype none
module dmsh_dp (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              cfg_wr_en,
    input  wire logic [dmsh_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [dmsh_pkg::WORD_W-1:0]       cfg_wdata,
    input  wire logic [dmsh_pkg::WORD_W-1:0]       in_word_even,
    input  wire logic [dmsh_pkg::WORD_W-1:0]       in_word_odd,
    input  wire logic                              in_last,
    input  wire dmsh_pkg::ctrl_t                   ctrl,
    output dmsh_pkg::status_t                      status,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic [dmsh_pkg::WORD_W-1:0]            out_hash_first,
    output logic [dmsh_pkg::WORD_W-1:0]            out_hash_second
);
    import dmsh_pkg::*;

    logic [WORD_W-1:0] md5_first_reg, md5_second_reg;
    logic [WORD_W-1:0] wo_reg;
    logic              last_reg;
    logic [WORD_W-1:0] ra_reg, rb_reg, rt_reg;
    logic [WORD_W-1:0] chk_a_reg, chk_a_next, chk_b_reg, chk_b_next;
    logic [WORD_W-1:0] tot_a_reg, tot_a_next, tot_b_reg, tot_b_next;
    logic [WORD_W-1:0] hash1_reg, hash2_reg;
    logic              m_tvalid_reg, m_tvalid_next;

    logic [WORD_W-1:0]   key, x_op, y_op, addend, mul_res;
    logic [2*WORD_W-1:0] mul_full;
    logic [WORD_W-1:0]   sum_a, sum_b;

    assign key = (ctrl.cw.row ? md5_second_reg : md5_first_reg) | 32'd1;

    always_comb begin
        case (ctrl.cw.xsel)
            X_RA:      x_op = ra_reg;
            X_SWAP_RA: x_op = {ra_reg[15:0], ra_reg[31:16]};
            X_RB:      x_op = rb_reg;
            X_SWAP_RB: x_op = {rb_reg[15:0], rb_reg[31:16]};
            X_RB_HI:   x_op = {16'd0, rb_reg[31:16]};
            default:   x_op = ra_reg;
        endcase
    end

    assign y_op = (ctrl.cw.ysel == Y_TABLE) ?
                  scr_const(ctrl.cw.tab, ctrl.cw.row, ctrl.cw.kidx) : key;

    always_comb begin
        case (ctrl.cw.addsel)
            ADD_RT:  addend = rt_reg;
            ADD_RB:  addend = rb_reg;
            default: addend = '0;
        endcase
    end

    assign mul_full = x_op * y_op;
    assign mul_res  = mul_full[WORD_W-1:0] + addend;

    assign sum_a = tot_a_reg + ra_reg;
    assign sum_b = tot_b_reg + rb_reg;

    // commit of the scrambled words into checksums and totals, cleared at the end of a last block
    always_comb begin
        chk_a_next    = chk_a_reg;
        chk_b_next    = chk_b_reg;
        tot_a_next    = tot_a_reg;
        tot_b_next    = tot_b_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        if (ctrl.adv && (ctrl.cw.op == OP_MID || ctrl.cw.op == OP_END)) begin
            chk_a_next = ra_reg;
            chk_b_next = rb_reg;
            tot_a_next = sum_a;
            tot_b_next = sum_b;
            if (ctrl.cw.op == OP_END && last_reg) begin
                chk_a_next    = '0;
                chk_b_next    = '0;
                tot_a_next    = '0;
                tot_b_next    = '0;
                m_tvalid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            md5_first_reg  <= '0;
            md5_second_reg <= '0;
            chk_a_reg      <= '0;
            chk_b_reg      <= '0;
            tot_a_reg      <= '0;
            tot_b_reg      <= '0;
            m_tvalid_reg   <= 1'b0;
            last_reg       <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_MD5_FIRST:  md5_first_reg  <= cfg_wdata;
                    REG_MD5_SECOND: md5_second_reg <= cfg_wdata;
                    default: ;
                endcase
            end
            chk_a_reg    <= chk_a_next;
            chk_b_reg    <= chk_b_next;
            tot_a_reg    <= tot_a_next;
            tot_b_reg    <= tot_b_next;
            m_tvalid_reg <= m_tvalid_next;
            if (ctrl.adv && ctrl.cw.op == OP_WAIT) begin
                last_reg <= in_last;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.adv) begin
            case (ctrl.cw.op)
                OP_WAIT: begin
                    wo_reg <= in_word_odd;
                    ra_reg <= chk_a_reg + in_word_even;
                    rb_reg <= chk_b_reg + in_word_even;
                end
                OP_MID: begin
                    // checksums become ra/rb in this same step
                    ra_reg <= ra_reg + wo_reg;
                    rb_reg <= rb_reg + wo_reg;
                end
                OP_END: begin
                    if (last_reg) begin
                        hash1_reg <= ra_reg ^ rb_reg;
                        hash2_reg <= sum_a ^ sum_b;
                    end
                end
                default: begin
                    case (ctrl.cw.dst)
                        D_RA:    ra_reg <= mul_res;
                        D_RB:    rb_reg <= mul_res;
                        default: rt_reg <= mul_res;
                    endcase
                end
            endcase
        end
    end

    assign status.last     = last_reg;
    assign status.out_busy = m_tvalid_reg && !m_tready;
    assign m_tvalid        = m_tvalid_reg;
    assign out_hash_first  = hash1_reg;
    assign out_hash_second = hash2_reg;

endmodule
`default_nettype wire

### hdl/dual_multiply_scramble_hash_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// A final block's hash and m_tvalid register at its end step. A block takes an accept step
// and 22 microcode steps, twenty sharing one 32x32 multiplier; no new block is accepted until
// they end. The end step of a final block holds while an earlier hash is not taken.
// Reset (aresetn low, synchronous) clears checksums, totals, md5 words, output valid and
// returns the sequencer to its wait step.
module dual_multiply_scramble_hash_unit (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           cfg_wr_en,
    input  wire logic [dmsh_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [31:0]                    cfg_wdata,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [63:0]                    s_tdata,   // word_even, word_odd
    input  wire logic                           s_tlast,   // last_block
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic [63:0]                         m_tdata    // hash_word_first, hash_word_second
);
    import dmsh_pkg::*;

    ctrl_t   ctrl;
    status_t status;

    dmsh_seq u_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .ctrl     (ctrl)
    );

    dmsh_dp u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .in_word_even    (s_tdata[31:0]),
        .in_word_odd     (s_tdata[63:32]),
        .in_last         (s_tlast),
        .ctrl            (ctrl),
        .status          (status),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .out_hash_first  (m_tdata[31:0]),
        .out_hash_second (m_tdata[63:32])
    );

endmodule
`default_nettype wire

### tb/sv/tb.sv
`timescale 1ns / 1ps
module tb;
    import dmsh_pkg::*;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int SETTLE      = 30;   // settle time after the final block

    typedef struct packed {
        logic [31:0] word_even;
        logic [31:0] word_odd;
        logic        last_block;
    } block_req_t;

    typedef struct packed {
        logic [31:0] hash_word_first;
        logic [31:0] hash_word_second;
    } hash_t;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = REG_MD5_FIRST;
    logic [31:0]          cfg_wdata = '0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [63:0]          s_tdata   = '0;   // word_even, word_odd
    logic                 s_tlast   = 1'b0; // last_block
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [63:0]          m_tdata;          // hash_word_first, hash_word_second

    dual_multiply_scramble_hash_unit i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // hash state and register copies
    logic [31:0] key_first, key_second;
    logic [31:0] chk_a, chk_b, sum_a, sum_b;

    block_req_t blocks_pending[$];
    hash_t      hashes_due[$];
    block_req_t drv_blk;
    int         gap_cnt   = 0;
    int         stall_cnt = 0;
    bit         quiet_src  = 1'b0;
    bit         quiet_sink = 1'b0;
    int         fails  = 0;
    int         cycles = 0;

    function automatic logic [31:0] swap16(input logic [31:0] x);
        return {x[15:0], x[31:16]};
    endfunction

    // multipliers of the swap-multiply chain
    function automatic logic [31:0] spin_k(input bit row, input logic [1:0] k);
        case ({row, k})
            3'b000:  return 32'hCF98B111;
            3'b001:  return 32'h87085B9F;
            3'b010:  return 32'h12CEB96D;
            3'b011:  return 32'h257E1D83;
            3'b100:  return 32'hA27416F5;
            3'b101:  return 32'hD38396FF;
            3'b110:  return 32'h7C932B89;
            default: return 32'hBFA49F69;
        endcase
    endfunction

    // multipliers of the shift-multiply-add chain
    function automatic logic [31:0] blend_k(input bit row, input logic [1:0] k);
        case ({row, k})
            3'b000:  return 32'hEF0569FB;
            3'b001:  return 32'h689B6B9F;
            3'b010:  return 32'h79F8A395;
            3'b011:  return 32'hC3EFEA97;
            3'b100:  return 32'hC31713DB;
            3'b101:  return 32'hDDCD1F0F;
            3'b110:  return 32'h59C3AF2D;
            default: return 32'h35BD1EC9;
        endcase
    endfunction

    task automatic mix_word(input logic [31:0] w, input logic [31:0] key, input bit row);
        logic [31:0] a, b;
        a = (chk_a + w) * key;
        for (int i = 0; i < 4; i++)
            a = swap16(a) * spin_k(row, i[1:0]);
        b = chk_b + w;
        b = swap16(b) * blend_k(row, 2'd0) + b * key;
        b = (b >> 16) * blend_k(row, 2'd1) + b * blend_k(row, 2'd2);
        b = swap16(b) * blend_k(row, 2'd3) + b;
        chk_a = a;
        chk_b = b;
        sum_a = sum_a + a;
        sum_b = sum_b + b;
    endtask

    task automatic fold_block(input logic [31:0] we, input logic [31:0] wo, input logic last);
        hash_t h;
        mix_word(we, key_first | 32'd1, 1'b0);
        mix_word(wo, key_second | 32'd1, 1'b1);
        if (last) begin
            h.hash_word_first  = chk_a ^ chk_b;
            h.hash_word_second = sum_a ^ sum_b;
            hashes_due.push_back(h);
            chk_a = '0;
            chk_b = '0;
            sum_a = '0;
            sum_b = '0;
        end
    endtask

    function automatic int pause_len(input bit quiet);
        int r;
        r = $urandom_range(0, 99);
        if (quiet) return 0;
        if (r < 70) return $urandom_range(1, 3);
        if (r < 93) return $urandom_range(4, 24);
        return $urandom_range(25, 90);
    endfunction

    // request driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            gap_cnt  <= 0;
        end else begin
            if (s_tvalid && s_tready)
                fold_block(s_tdata[31:0], s_tdata[63:32], s_tlast);
            if (!s_tvalid || s_tready) begin
                if (gap_cnt > 0) begin
                    gap_cnt  <= gap_cnt - 1;
                    s_tvalid <= 1'b0;
                end else if (blocks_pending.size() != 0) begin
                    drv_blk  = blocks_pending.pop_front();
                    s_tdata  <= {drv_blk.word_odd, drv_blk.word_even};
                    s_tlast  <= drv_blk.last_block;
                    s_tvalid <= 1'b1;
                    gap_cnt  <= ($urandom_range(0, 3) == 0) ? pause_len(quiet_src) : 0;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // hash monitor
    always @(posedge aclk) begin
        hash_t want;
        if (!aresetn) begin
            m_tready  <= 1'b0;
            stall_cnt <= 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (hashes_due.size() == 0) begin
                    $error("unexpected hash %h", m_tdata);
                    fails++;
                end else begin
                    want = hashes_due.pop_front();
                    if (m_tdata[31:0] !== want.hash_word_first) begin
                        $error("hash_word_first: expected %h, got %h",
                               want.hash_word_first, m_tdata[31:0]);
                        fails++;
                    end
                    if (m_tdata[63:32] !== want.hash_word_second) begin
                        $error("hash_word_second: expected %h, got %h",
                               want.hash_word_second, m_tdata[63:32]);
                        fails++;
                    end
                end
            end
            if (stall_cnt > 0) begin
                stall_cnt <= stall_cnt - 1;
                m_tready  <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                if ($urandom_range(0, 9) < 3)
                    stall_cnt <= pause_len(quiet_sink);
            end
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        if (idx == REG_MD5_FIRST) key_first = val;
        else key_second = val;
    endtask

    task automatic add_block(input logic [31:0] we, input logic [31:0] wo, input logic last);
        block_req_t b;
        b.word_even  = we;
        b.word_odd   = wo;
        b.last_block = last;
        blocks_pending.push_back(b);
    endtask

    // hold until every block is taken and every hash has come, then let the
    // sequencer finish any non-final block
    task automatic drain();
        @(negedge aclk);
        while (blocks_pending.size() != 0 || s_tvalid || hashes_due.size() != 0)
            @(negedge aclk);
        repeat (SETTLE) @(negedge aclk);
    endtask

    function automatic logic [31:0] pick_word();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8)  return 32'h0;
        if (r < 16) return 32'hFFFFFFFF;
        if (r < 22) return 32'h1 << $urandom_range(0, 31);
        return $urandom;
    endfunction

    function automatic logic [31:0] pick_key();
        case ($urandom_range(0, 7))
            0:       return 32'h0;
            1:       return 32'hFFFFFFFF;
            2:       return 32'hFFFFFFFE;
            3:       return 32'h1;
            default: return $urandom;
        endcase
    endfunction

    initial begin
        int sent;
        int msg_left;
        int n;
        key_first  = '0;
        key_second = '0;
        chk_a = '0;
        chk_b = '0;
        sum_a = '0;
        sum_b = '0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // registers at their reset value
        @(negedge aclk);
        add_block(32'h00000000, 32'h00000000, 1'b1);
        add_block(32'hFFFFFFFF, 32'hFFFFFFFF, 1'b1);
        add_block(32'hFFFFFFFF, 32'h00000000, 1'b1);
        add_block(32'h00000000, 32'hFFFFFFFF, 1'b0);
        add_block(32'h12345678, 32'h9ABCDEF0, 1'b1);
        drain();

        // top values, bit 0 already clear on the second word
        write_reg(REG_MD5_FIRST, 32'hFFFFFFFF);
        write_reg(REG_MD5_SECOND, 32'hFFFFFFFE);
        @(negedge aclk);
        add_block(32'h00000000, 32'h00000000, 1'b1);
        add_block(32'hFFFFFFFF, 32'hFFFFFFFF, 1'b0);
        add_block(32'h80000001, 32'h7FFFFFFE, 1'b0);
        add_block(32'hA5A5A5A5, 32'h5A5A5A5A, 1'b0);
        drain();

        // change keys in the middle of a message
        write_reg(REG_MD5_FIRST, 32'h00000001);
        write_reg(REG_MD5_SECOND, 32'h00000000);
        @(negedge aclk);
        add_block(32'h0000FFFF, 32'hFFFF0000, 1'b1);
        add_block(32'hFFFFFFFF, 32'hFFFFFFFF, 1'b1);
        drain();

        sent     = 0;
        msg_left = 0;
        while (sent < 800) begin
            if ($urandom_range(0, 2) != 0) write_reg(REG_MD5_FIRST, pick_key());
            if ($urandom_range(0, 2) != 0) write_reg(REG_MD5_SECOND, pick_key());
            @(negedge aclk);
            quiet_src  = ($urandom_range(0, 4) == 0);
            quiet_sink = ($urandom_range(0, 4) == 0);
            n = $urandom_range(20, 120);
            if (n > 800 - sent) n = 800 - sent;
            repeat (n) begin
                if (msg_left == 0) begin
                    n = $urandom_range(0, 99);
                    if (n < 70)      msg_left = $urandom_range(1, 4);
                    else if (n < 95) msg_left = $urandom_range(5, 16);
                    else             msg_left = $urandom_range(17, 60);
                end
                add_block(pick_word(), pick_word(), msg_left == 1);
                msg_left--;
                sent++;
            end
            drain();
        end

        repeat (SETTLE) @(negedge aclk);
        if (fails == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

### files.f
hdl/dmsh_pkg.sv
hdl/dmsh_seq.sv
hdl/dmsh_dp.sv
hdl/dual_multiply_scramble_hash_unit.sv
tb/sv/tb.sv
